// ===== hdl/sbsf_pkg.sv =====
// shared constants and codes for the second-block stream filter
package sbsf_pkg;

  // bytes held back at the head of every block
  localparam int HEADER_BYTES = 10;
  // offset of the bcd second within a block
  localparam int SECOND_INDEX = 9;
  // shortest legal block length
  localparam int MIN_LENGTH = 10;
  // largest legal bcd tens digit and units digit
  localparam int MAX_TENS = 5;
  localparam int MAX_UNITS = 9;
  // default depth of the result queue, a power of two above HEADER_BYTES
  localparam int QUEUE_DEPTH_DEFAULT = 16;

  localparam int MASK_W = 60;
  localparam int LEN_W = 32;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // summary status codes
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

endpackage

// ===== hdl/second_block_stream_filter_core.sv =====
// second-block stream filter: header hold-back, second selection and summary
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------------
//  input    | in_valid / in_ready         | in_byte, end_of_file
//  output   | out_valid / out_ready       | out_kind, out_byte, selected_total, status,
//           |                             | last_of_run
//  config   | second_mask_we              | second_mask
//
// one input item is taken per cycle while in_ready is high; header bytes and body bytes of
// a kept block go straight into a small result queue, header bytes uncommitted until
// byte 9 decides the block, so a kept header drains at one item per cycle while out_ready
// holds and the following bytes keep arriving; items pass through the queue and the output
// register, and queue depth sets how far output stalls can be absorbed
// after an end_of_file item the input is held off until the summary has been loaded
// rst is synchronous and clears the queue pointers, the stream state but len_hi, and the mask to all ones
module second_block_stream_filter_core #(
  parameter int QUEUE_DEPTH = sbsf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           second_mask_we,
  input  logic [sbsf_pkg::MASK_W-1:0]    second_mask,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  input  logic                           end_of_file,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_kind,
  output logic [7:0]                     out_byte,
  output logic [sbsf_pkg::LEN_W-1:0]     selected_total,
  output logic [1:0]                     status,
  output logic                           last_of_run
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int LEN_W = sbsf_pkg::LEN_W;

  // selection mask
  logic [sbsf_pkg::MASK_W-1:0] sec_mask;

  // stream state
  logic [LEN_W-1:0] pos, pos_next;
  logic [LEN_W-1:0] blen, blen_next;
  logic             keep, keep_next;
  logic [LEN_W-1:0] total, total_next;
  logic             ferr, ferr_next;
  logic [23:0]      len_hi, len_hi_next;

  // result queue: rd up to cm is committed, cm up to wr is a header still on hold
  logic [7:0] q_byte [QUEUE_DEPTH];
  logic       q_last [QUEUE_DEPTH];
  logic [PTR_W:0] rd, wr, wr_next, cm, cm_next;
  logic [PTR_W:0] used;
  logic           q_we;

  // pending summary
  logic             sum_pend;
  logic             sum_load;
  logic [LEN_W-1:0] sum_total, sum_total_next;
  logic [1:0]       sum_status, sum_status_next;

  logic in_fire;
  logic out_load;

  // per-item helpers
  logic [LEN_W-1:0] blen_cur;
  logic [LEN_W:0]   sum_wide;
  logic [LEN_W-1:0] total_sat;
  logic [3:0]       bcd_hi, bcd_lo;
  logic             bcd_ok;
  logic [6:0]       sec_num;
  logic [127:0]     mask_ext;
  logic             keep_hit;

  assign used     = wr - rd;
  assign in_ready = !sum_pend && (used != (PTR_W+1)'(QUEUE_DEPTH));
  assign in_fire  = in_valid && in_ready;
  assign out_load = !out_valid || out_ready;

  // bcd second decode and mask lookup
  assign bcd_hi   = in_byte[7:4];
  assign bcd_lo   = in_byte[3:0];
  assign bcd_ok   = (bcd_hi <= 4'(sbsf_pkg::MAX_TENS)) && (bcd_lo <= 4'(sbsf_pkg::MAX_UNITS));
  assign sec_num  = {bcd_hi, 3'b000} + {2'b00, bcd_hi, 1'b0} + {3'b000, bcd_lo};
  assign mask_ext = {{(128 - sbsf_pkg::MASK_W){1'b0}}, sec_mask};
  assign keep_hit = bcd_ok && mask_ext[sec_num];

  // saturating add of the current length to the running total
  assign sum_wide  = {1'b0, total} + {1'b0, blen};
  assign total_sat = sum_wide[LEN_W] ? {LEN_W{1'b1}} : sum_wide[LEN_W-1:0];

  // one input item: parse, queue and decide
  always_comb begin
    pos_next        = pos;
    blen_next       = blen;
    keep_next       = keep;
    total_next      = total;
    ferr_next       = ferr;
    len_hi_next     = len_hi;
    wr_next         = wr;
    cm_next         = cm;
    q_we            = 1'b0;
    sum_load        = 1'b0;
    sum_total_next  = sum_total;
    sum_status_next = sum_status;
    blen_cur        = blen;
    if (in_fire) begin
      if (!ferr) begin
        if (pos < LEN_W'(4)) begin
          len_hi_next = {len_hi[15:0], in_byte};
        end
        if (pos == LEN_W'(3)) begin
          blen_cur  = {len_hi, in_byte};
          blen_next = blen_cur;
          if (blen_cur < LEN_W'(sbsf_pkg::MIN_LENGTH)) begin
            ferr_next = 1'b1;
          end
        end
        if (!ferr_next) begin
          if (pos < LEN_W'(sbsf_pkg::HEADER_BYTES)) begin
            // header byte on hold
            q_we    = 1'b1;
            wr_next = wr + (PTR_W+1)'(1);
          end else if (keep) begin
            // body byte of a kept block goes out at once
            q_we    = 1'b1;
            wr_next = wr + (PTR_W+1)'(1);
            cm_next = wr + (PTR_W+1)'(1);
          end
          if (pos == LEN_W'(sbsf_pkg::SECOND_INDEX)) begin
            if (keep_hit) begin
              keep_next  = 1'b1;
              cm_next    = wr + (PTR_W+1)'(1);
              total_next = total_sat;
            end else begin
              keep_next = 1'b0;
              wr_next   = cm;
            end
          end
          if ((pos >= LEN_W'(3)) && (pos == blen_cur - LEN_W'(1))) begin
            pos_next  = '0;
            keep_next = 1'b0;
          end else begin
            pos_next = pos + LEN_W'(1);
          end
        end else begin
          // short length: held header bytes are thrown away
          wr_next = cm;
        end
      end
      if (end_of_file) begin
        sum_load       = 1'b1;
        sum_total_next = total_next;
        if (ferr_next) begin
          sum_status_next = sbsf_pkg::STATUS_SHORT;
        end else if (pos_next != '0) begin
          sum_status_next = sbsf_pkg::STATUS_TRUNC;
        end else begin
          sum_status_next = sbsf_pkg::STATUS_OK;
        end
        // anything still on hold is never released
        wr_next    = cm_next;
        pos_next   = '0;
        blen_next  = '0;
        keep_next  = 1'b0;
        total_next = '0;
        ferr_next  = 1'b0;
      end
    end
  end

  // queue storage, no reset; header bytes ahead of the second are released by a
  // later item, so they never close a run of results
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_byte[wr[PTR_W-1:0]] <= in_byte;
      q_last[wr[PTR_W-1:0]] <= !end_of_file && (pos >= LEN_W'(sbsf_pkg::SECOND_INDEX));
    end
  end

  // summary payload
  always_ff @(posedge clk) begin
    if (sum_load) begin
      sum_total  <= sum_total_next;
      sum_status <= sum_status_next;
    end
  end

  // control and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_mask  <= {sbsf_pkg::MASK_W{1'b1}};
      pos       <= '0;
      blen      <= '0;
      keep      <= 1'b0;
      total     <= '0;
      ferr      <= 1'b0;
      wr        <= '0;
      cm        <= '0;
      rd        <= '0;
      sum_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (second_mask_we) begin
        sec_mask <= second_mask;
      end
      pos   <= pos_next;
      blen  <= blen_next;
      keep  <= keep_next;
      total <= total_next;
      ferr  <= ferr_next;
      wr    <= wr_next;
      cm    <= cm_next;
      if (out_load) begin
        if (rd != cm) begin
          out_valid <= 1'b1;
          rd        <= rd + (PTR_W+1)'(1);
        end else if (sum_pend) begin
          out_valid <= 1'b1;
          sum_pend  <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
      if (sum_load) begin
        sum_pend <= 1'b1;
      end
    end
  end

  // length bytes, no reset
  always_ff @(posedge clk) begin
    len_hi <= len_hi_next;
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (rd != cm) begin
        out_kind       <= sbsf_pkg::KIND_DATA;
        out_byte       <= q_byte[rd[PTR_W-1:0]];
        selected_total <= '0;
        status         <= sbsf_pkg::STATUS_OK;
        last_of_run    <= q_last[rd[PTR_W-1:0]];
      end else begin
        out_kind       <= sbsf_pkg::KIND_SUMMARY;
        out_byte       <= '0;
        selected_total <= sum_total;
        status         <= sum_status;
        last_of_run    <= 1'b1;
      end
    end
  end

endmodule
